// ===== rtl/core/event_statistics_table_core_defines.svh =====
// Assertion macros used by the statistics table core.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef EVENT_STATISTICS_TABLE_CORE_DEFINES_SVH
`define EVENT_STATISTICS_TABLE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/est_pkg.sv =====
// Package for the event statistics table: sizes, mode codes and the entry type.
// Used by est_entry_update and event_statistics_table_core; depends on nothing.
`default_nettype none

package est_pkg;

	// Table geometry.
	localparam int NUM_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int IDX_W       = 6;
	localparam int VAL_W       = 64;
	localparam int MODE_W      = 3;

	// Mode codes carried in the input tuser.
	localparam logic [MODE_W-1:0] MODE_COUNT    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SIZE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TIME     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MERGE    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ     = 3'd5;

	// Stream widths.
	localparam int IN_DATA_W  = 520;
	localparam int OUT_DATA_W = 448;

	// One statistics entry; least and most of zero mean empty.
	typedef struct packed {
		logic [VAL_W-1:0] time_most;
		logic [VAL_W-1:0] time_least;
		logic [VAL_W-1:0] time_total;
		logic [VAL_W-1:0] size_most;
		logic [VAL_W-1:0] size_least;
		logic [VAL_W-1:0] size_total;
		logic [VAL_W-1:0] count;
	} entry_t;

	// Operation handed to the update logic.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              in_range;
	} upd_op_t;

	// Outcome reported by the update logic.
	typedef struct packed {
		logic changes;
	} upd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/est_entry_update.sv =====
// Combinational update of one statistics entry for one transaction.
// Depends on est_pkg for the entry type and mode codes.
`default_nettype none

module est_entry_update (
	input  est_pkg::upd_op_t               op,
	input  logic [est_pkg::VAL_W-1:0]      sample,
	input  est_pkg::entry_t                other,
	input  est_pkg::entry_t                old_entry,
	output est_pkg::entry_t                new_entry,
	output est_pkg::upd_stat_t             stat
);

	// Sample rule: zero extreme counts as empty.
	function automatic logic [est_pkg::VAL_W-1:0] smp_min(
		input logic [est_pkg::VAL_W-1:0] own, input logic [est_pkg::VAL_W-1:0] v);
		return ((own > v) || (own == '0)) ? v : own;
	endfunction

	function automatic logic [est_pkg::VAL_W-1:0] smp_max(
		input logic [est_pkg::VAL_W-1:0] own, input logic [est_pkg::VAL_W-1:0] v);
		return ((own < v) || (own == '0)) ? v : own;
	endfunction

	// Merge rule: an empty other extreme only replaces an empty own extreme.
	function automatic logic [est_pkg::VAL_W-1:0] mrg_min(
		input logic [est_pkg::VAL_W-1:0] own, input logic [est_pkg::VAL_W-1:0] oth);
		return (((oth != '0) && (own > oth)) || (own == '0)) ? oth : own;
	endfunction

	function automatic logic [est_pkg::VAL_W-1:0] mrg_max(
		input logic [est_pkg::VAL_W-1:0] own, input logic [est_pkg::VAL_W-1:0] oth);
		return (((oth != '0) && (own < oth)) || (own == '0)) ? oth : own;
	endfunction

	// Per-mode next value of the entry.
	always_comb begin
		new_entry    = old_entry;
		stat.changes = 1'b0;
		if (op.in_range) begin
			unique case (op.mode)
				est_pkg::MODE_COUNT: begin
					new_entry.count = old_entry.count + est_pkg::VAL_W'(1);
					stat.changes    = 1'b1;
				end
				est_pkg::MODE_SIZE: begin
					new_entry.size_total = old_entry.size_total + sample;
					new_entry.size_least = smp_min(old_entry.size_least, sample);
					new_entry.size_most  = smp_max(old_entry.size_most, sample);
					stat.changes         = 1'b1;
				end
				est_pkg::MODE_TIME: begin
					new_entry.time_total = old_entry.time_total + sample;
					new_entry.time_least = smp_min(old_entry.time_least, sample);
					new_entry.time_most  = smp_max(old_entry.time_most, sample);
					stat.changes         = 1'b1;
				end
				est_pkg::MODE_MERGE: begin
					new_entry.count      = old_entry.count + other.count;
					new_entry.size_total = old_entry.size_total + other.size_total;
					new_entry.time_total = old_entry.time_total + other.time_total;
					new_entry.size_least = mrg_min(old_entry.size_least, other.size_least);
					new_entry.size_most  = mrg_max(old_entry.size_most, other.size_most);
					new_entry.time_least = mrg_min(old_entry.time_least, other.time_least);
					new_entry.time_most  = mrg_max(old_entry.time_most, other.time_most);
					stat.changes         = 1'b1;
				end
				est_pkg::MODE_SUBTRACT: begin
					new_entry.count      = old_entry.count - other.count;
					new_entry.size_total = old_entry.size_total - other.size_total;
					new_entry.time_total = old_entry.time_total - other.time_total;
					stat.changes         = 1'b1;
				end
				// Read and the unused codes leave the entry alone.
				default: begin
					new_entry    = old_entry;
					stat.changes = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/event_statistics_table_core.sv =====
// Event statistics table: input stage, entry memory with bypass, update, result register.
// Depends on est_pkg, est_entry_update and event_statistics_table_core_defines.svh.
// ---------------------------------------------------------------------------
// Usage:
// Input transactions arrive on s_axis; tuser carries the mode (count, size
// sample, time sample, merge, subtract, read) and tdata the entry index, the
// sample and the other table's entry. Each transaction yields exactly one
// result transaction on m_axis: the addressed entry after the update in tdata
// and the table-wide used flag in tuser.
// Timing: an accepted transaction is registered in stage 1 together with the
// memory read of its entry; when stage 1 advances, the update is applied and
// the result registered in the result register, raising m_axis_tvalid.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the single read port and single write port of the entry memory;
// back-to-back updates to the same entry are served from a bypass register
// holding the last written entry.
// Reset clears the per-entry valid bits, the used flag and all handshake
// state; an entry that was never written reads as zero, so no clearing pass
// is needed and the block is ready right after reset.
// When the receiver stalls, the result register holds, the input stage holds
// one more transaction, and s_axis_tready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "event_statistics_table_core_defines.svh"

module event_statistics_table_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata: entry_index[5:0], sample, other_count, other_size_total,
	// other_time_total, other_size_min, other_size_max, other_time_min,
	// other_time_max (64 bits each, from bit 6 up), two zero pad bits.
	input  logic [est_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// tuser: mode[2:0].
	input  logic [est_pkg::MODE_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata: event_count, size_total, size_least, size_most, time_total,
	// time_least, time_most (64 bits each, lowest first).
	output logic [est_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// tuser: table_used[0].
	output logic                             m_axis_tuser
);

	localparam int V = est_pkg::VAL_W;
	localparam int I = est_pkg::IDX_W;

	// Unpack the input transaction.
	logic [I-1:0]        in_idx;
	logic [V-1:0]        in_sample;
	est_pkg::entry_t     in_other;
	logic                in_rng;
	logic [est_pkg::ADDR_W-1:0] in_addr;

	always_comb begin
		in_idx              = s_axis_tdata[I-1:0];
		in_sample           = s_axis_tdata[I+V-1:I];
		in_other            = '0;
		in_other.count      = s_axis_tdata[I+2*V-1:I+V];
		in_other.size_total = s_axis_tdata[I+3*V-1:I+2*V];
		in_other.time_total = s_axis_tdata[I+4*V-1:I+3*V];
		in_other.size_least = s_axis_tdata[I+5*V-1:I+4*V];
		in_other.size_most  = s_axis_tdata[I+6*V-1:I+5*V];
		in_other.time_least = s_axis_tdata[I+7*V-1:I+6*V];
		in_other.time_most  = s_axis_tdata[I+8*V-1:I+7*V];
		in_rng              = ({1'b0, in_idx} < (I+1)'(est_pkg::NUM_ENTRIES));
		in_addr             = in_idx[est_pkg::ADDR_W-1:0];
	end

	// Stage 1 and result stage registers.
	logic                       vld_s1;
	logic [est_pkg::MODE_W-1:0] mode_s1;
	logic                       rng_s1;
	logic [est_pkg::ADDR_W-1:0] addr_s1;
	logic [V-1:0]               sample_s1;
	est_pkg::entry_t            other_s1;
	est_pkg::entry_t            rd_s1;
	logic                       ent_vld_s1;
	logic                       fwd_hit_s1;

	logic                       vld_s2;
	est_pkg::entry_t            res_s2;
	logic                       used_s2;

	logic [est_pkg::NUM_ENTRIES-1:0] ent_vld_q;
	est_pkg::entry_t            entry_mem_q [est_pkg::NUM_ENTRIES];
	est_pkg::entry_t            fwd_q;
	logic                       used_q;

	// Handshake control.
	logic adv_s1;
	logic load_s1;
	logic wr_en;

	assign adv_s1        = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s1;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	// Entry seen by the update: bypass, then memory, then zero for unwritten entries.
	est_pkg::entry_t    old_entry;
	est_pkg::entry_t    new_entry;
	est_pkg::upd_op_t   upd_op;
	est_pkg::upd_stat_t upd_stat;

	always_comb begin
		if (fwd_hit_s1) begin
			old_entry = fwd_q;
		end else if (ent_vld_s1) begin
			old_entry = rd_s1;
		end else begin
			old_entry = '0;
		end
		upd_op.mode     = mode_s1;
		upd_op.in_range = rng_s1;
	end

	est_entry_update u_update (
		.op        (upd_op),
		.sample    (sample_s1),
		.other     (other_s1),
		.old_entry (old_entry),
		.new_entry (new_entry),
		.stat      (upd_stat)
	);

	assign wr_en = adv_s1 && upd_stat.changes;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			ent_vld_s1 <= 1'b0;
			vld_s2     <= 1'b0;
			ent_vld_q  <= '0;
			used_q     <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1     <= 1'b1;
				fwd_hit_s1 <= wr_en && (addr_s1 == in_addr);
				ent_vld_s1 <= ent_vld_q[in_addr];
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				vld_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				vld_s2 <= 1'b0;
			end
			if (wr_en) begin
				ent_vld_q[addr_s1] <= 1'b1;
				used_q             <= 1'b1;
			end
		end
	end

	// Payload registers and the entry memory.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1   <= s_axis_tuser;
			rng_s1    <= in_rng;
			addr_s1   <= in_addr;
			sample_s1 <= in_sample;
			other_s1  <= in_other;
			rd_s1     <= entry_mem_q[in_addr];
		end
		if (wr_en) begin
			entry_mem_q[addr_s1] <= new_entry;
			fwd_q                <= new_entry;
		end
		if (adv_s1) begin
			res_s2  <= rng_s1 ? new_entry : '0;
			used_s2 <= used_q || upd_stat.changes;
		end
	end

	// Result stream.
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tuser  = used_s2;
	assign m_axis_tdata  = {res_s2.time_most, res_s2.time_least, res_s2.time_total,
	                        res_s2.size_most, res_s2.size_least, res_s2.size_total,
	                        res_s2.count};

	// Checks.
	`EST_ASSERT_NEXT(a_used_sticky, used_q, used_q, "used flag cleared after being set")
	`EST_ASSERT_NOW(a_stall_blocks_input, vld_s1 && vld_s2 && !m_axis_tready, !s_axis_tready, "input accepted while both stages are full")
	`EST_ASSERT_NEXT(a_write_marks_valid, wr_en, ent_vld_q[$past(addr_s1)] && used_q, "written entry not marked valid")
	`EST_ASSERT_NOW(a_write_needs_slot, wr_en, vld_s1 && (!vld_s2 || m_axis_tready), "entry written without the result advancing")

endmodule

`default_nettype wire
